FILE: rtl/ckeb_pkg.sv
package ckeb_pkg;

  localparam int WINDOW  = 1024;
  localparam int AW      = $clog2(WINDOW);
  localparam int LW      = AW + 1;              // holds 0 .. WINDOW
  localparam int MAX_K   = 6;
  localparam int KW      = $clog2(MAX_K + 1);   // holds 0 .. MAX_K
  localparam int RW      = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int IDX_W   = 20;
  localparam int COORD_W = 24;
  localparam int SQ_W    = 2 * COORD_W;         // one squared difference
  localparam int DW      = SQ_W + 2;            // s + t
  localparam int LEN_W   = 26;
  localparam int TOT_W   = 32;
  localparam int TW_W    = 16;
  localparam int MARG_W  = 20;
  localparam int NC_W    = 3;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 20;
  localparam int ITER    = DW / 2;
  localparam int CW      = $clog2(ITER + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FAW     = $clog2(FIFO_DEPTH);

  localparam logic [TW_W-1:0]   TW_RESET   = 16'd5898;
  localparam logic [MARG_W-1:0] MARG_RESET = 20'd1;
  localparam logic [NC_W-1:0]   NC_RESET   = 3'd6;

  typedef enum logic [CFG_IW-1:0] {
    CFG_TIME_WEIGHT   = 2'd0,
    CFG_CAUSAL_MARGIN = 2'd1,
    CFG_NEIGH_COUNT   = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] t;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } hit_t;

  typedef struct packed {
    logic [IDX_W-1:0] from_hit;
    logic [IDX_W-1:0] to_hit;
    logic [DW-1:0]    dsq;
    logic             last;
    logic [TOT_W-1:0] total;
  } edge_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/ckeb_front.sv
module ckeb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  ckeb_pkg::hit_t                in_hit,
  input  logic [ckeb_pkg::TW_W-1:0]     time_weight,
  input  logic [ckeb_pkg::MARG_W-1:0]   causal_margin,
  input  logic [ckeb_pkg::NC_W-1:0]     neighbour_count,
  input  ckeb_pkg::q_stat_t             q_stat,
  output logic                          q_push,
  output ckeb_pkg::edge_t               q_data
);
  import ckeb_pkg::*;

  localparam int NST = 5;  // mem, |diff|, square, sum/weight, compare

  front_state_t state_r, state_nxt;

  hit_t             win_mem [WINDOW];
  hit_t             rd_data_r;
  hit_t             cur_r;
  logic [IDX_W-1:0] i_r;
  logic [LW-1:0]    d_r;
  logic [LW-1:0]    look_r;
  logic [KW-1:0]    kk_r;
  logic [KW-1:0]    e_r;
  logic [TOT_W-1:0] total_r;

  logic [NST-1:0]   vld_r;
  logic [LW-1:0]    dp_r [NST];

  logic [COORD_W-1:0] mt_r, mx_r, my_r, mz_r;
  logic [SQ_W-1:0]    qt_r, qx_r, qy_r, qz_r;
  logic [DW-1:0]      s_r;
  logic [SQ_W-1:0]    t_r;
  logic [DW-1:0]      dd_r;
  logic               cz_r;

  logic [DW-1:0]    best_d_r [MAX_K];
  logic [IDX_W-1:0] best_i_r [MAX_K];
  logic [DW-1:0]    rec_d_r  [MAX_K];
  logic [KW-1:0]    bn_r;
  logic [LW-1:0]    caus_r;

  logic             rd_en, wr_en, accept, advance;
  logic [AW-1:0]    rd_addr;
  logic [KW-1:0]    kk_in;
  logic [TW_W+SQ_W-1:0] wprod;

  function automatic logic [COORD_W-1:0] absdiff(logic signed [COORD_W-1:0] a,
                                                 logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] df;
    logic [COORD_W:0]        mg;
    df = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    mg = df[COORD_W] ? (~df + 1'b1) : df;
    return mg[COORD_W-1:0];
  endfunction

  assign accept = (state_r == ST_IDLE) && in_push;
  assign in_full = (state_r != ST_IDLE);
  assign rd_addr = i_r[AW-1:0] - d_r[AW-1:0];
  assign wprod = qt_r * time_weight;

  always_comb begin
    if (neighbour_count == '0) kk_in = KW'(1);
    else if (5'(neighbour_count) > 5'(MAX_K)) kk_in = KW'(MAX_K);
    else kk_in = KW'(neighbour_count);
  end

  // window memory
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= win_mem[rd_addr];
    if (wr_en) win_mem[i_r[AW-1:0]] <= cur_r;
  end

  // distance pipeline
  always_ff @(posedge clk) begin
    mt_r <= absdiff(rd_data_r.t, cur_r.t);
    mx_r <= absdiff(rd_data_r.x, cur_r.x);
    my_r <= absdiff(rd_data_r.y, cur_r.y);
    mz_r <= absdiff(rd_data_r.z, cur_r.z);
    qt_r <= mt_r * mt_r;
    qx_r <= mx_r * mx_r;
    qy_r <= my_r * my_r;
    qz_r <= mz_r * mz_r;
    s_r  <= DW'(qx_r) + DW'(qy_r) + DW'(qz_r);
    t_r  <= wprod[TW_W+SQ_W-1:TW_W];
    cz_r <= ({1'b0, s_r} + (DW+1)'(causal_margin)) < (DW+1)'(t_r);
    dd_r <= s_r + DW'(t_r);
    dp_r[0] <= d_r;
    for (int p = 1; p < NST; p++) dp_r[p] <= dp_r[p-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[NST-2:0], rd_en};
  end

  // ranked insert of the compared hit
  logic [IDX_W-1:0] ins_j;
  logic [KW-1:0]    ins_pos;
  logic [DW-1:0]    nb_d [MAX_K];
  logic [IDX_W-1:0] nb_i [MAX_K];

  assign ins_j = i_r - IDX_W'(dp_r[NST-1]);

  always_comb begin
    ins_pos = '0;
    for (int p = 0; p < MAX_K; p++) begin
      if ((KW'(p) < bn_r) && ((best_d_r[p] < dd_r) ||
          ((best_d_r[p] == dd_r) && (best_i_r[p] > ins_j))))
        ins_pos = ins_pos + 1'b1;
    end
    for (int p = 0; p < MAX_K; p++) begin
      if (KW'(p) < ins_pos) begin
        nb_d[p] = best_d_r[p];
        nb_i[p] = best_i_r[p];
      end else if (KW'(p) == ins_pos) begin
        nb_d[p] = dd_r;
        nb_i[p] = ins_j;
      end else begin
        nb_d[p] = best_d_r[(p > 0) ? p - 1 : 0];
        nb_i[p] = best_i_r[(p > 0) ? p - 1 : 0];
      end
    end
  end

  // edge list for this hit
  logic             enough, all_earlier;
  logic [KW-1:0]    cb, rest, n_edges, f_idx;
  logic [TOT_W:0]   tot_sum;

  assign enough  = caus_r >= LW'(kk_r);
  assign cb      = enough ? kk_r : KW'(caus_r);
  assign rest    = kk_r - cb;
  assign all_earlier = (caus_r == '0) ? (IDX_W'(rest) >= i_r) : (IDX_W'(rest) > i_r);
  assign n_edges = enough ? kk_r : (cb + (all_earlier ? KW'(i_r) : rest));
  assign f_idx   = e_r - cb;
  assign tot_sum = {1'b0, total_r} + (TOT_W+1)'(kk_r);

  always_comb begin
    q_data.to_hit = i_r;
    q_data.last   = (e_r == n_edges - 1'b1);
    q_data.total  = total_r;
    if (e_r < cb) begin
      q_data.from_hit = best_i_r[e_r[RW-1:0]];
      q_data.dsq      = best_d_r[e_r[RW-1:0]];
    end else if (all_earlier) begin
      q_data.from_hit = IDX_W'(f_idx);
      q_data.dsq      = rec_d_r[RW'(i_r[KW-1:0] - 1'b1 - f_idx)];
    end else begin
      q_data.from_hit = i_r - 1'b1 - IDX_W'(f_idx);
      q_data.dsq      = rec_d_r[f_idx[RW-1:0]];
    end
  end

  // control
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    q_push    = 1'b0;
    advance   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_push) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (d_r <= look_r) rd_en = 1'b1;
        else state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (vld_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (n_edges == '0) begin
          advance   = 1'b1;
          state_nxt = ST_IDLE;
        end else if (!q_stat.full) begin
          q_push = 1'b1;
          if (q_data.last) begin
            advance   = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      total_r <= '0;
      bn_r    <= '0;
      caus_r  <= '0;
      e_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cur_r  <= in_hit;
        d_r    <= LW'(1);
        look_r <= (i_r < IDX_W'(WINDOW)) ? LW'(i_r) : LW'(WINDOW);
        kk_r   <= kk_in;
        bn_r   <= '0;
        caus_r <= '0;
      end
      if (rd_en) d_r <= d_r + 1'b1;
      if (vld_r[NST-1]) begin
        if (dp_r[NST-1] <= LW'(MAX_K))
          rec_d_r[RW'(dp_r[NST-1] - 1'b1)] <= dd_r;
        if (cz_r) begin
          caus_r <= caus_r + 1'b1;
          if (ins_pos < kk_r) begin
            for (int p = 0; p < MAX_K; p++) begin
              best_d_r[p] <= nb_d[p];
              best_i_r[p] <= nb_i[p];
            end
            if (bn_r < kk_r) bn_r <= bn_r + 1'b1;
          end
        end
      end
      if (wr_en) begin
        e_r <= '0;
        if (enough)
          total_r <= tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];
      end
      if (q_push) e_r <= e_r + 1'b1;
      if (advance) i_r <= i_r + 1'b1;
    end
  end

endmodule

FILE: rtl/ckeb_fifo.sv
module ckeb_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ckeb_pkg::edge_t    push_data,
  input  logic               pop,
  output ckeb_pkg::edge_t    pop_data,
  output ckeb_pkg::q_stat_t  stat
);
  import ckeb_pkg::*;

  edge_t        slot_r [FIFO_DEPTH];
  logic [FAW-1:0] wp_r, rp_r;
  logic [FAW:0]   cnt_r;
  logic           do_push, do_pop;

  assign stat.full  = (cnt_r == (FAW+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (FAW+1)'(do_push) - (FAW+1)'(do_pop);
    end
  end

endmodule

FILE: rtl/ckeb_back.sv
module ckeb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ckeb_pkg::q_stat_t            q_stat,
  input  ckeb_pkg::edge_t              q_data,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [ckeb_pkg::IDX_W-1:0]   out_from_hit,
  output logic [ckeb_pkg::IDX_W-1:0]   out_to_hit,
  output logic [ckeb_pkg::LEN_W-1:0]   out_edge_length,
  output logic                         out_last_edge,
  output logic [ckeb_pkg::TOT_W-1:0]   out_full_causal_edges
);
  import ckeb_pkg::*;

  back_state_t state_r, state_nxt;
  edge_t       ed_r;
  logic [DW-1:0] rem_r, root_r, bit_r, sum;
  logic [CW-1:0] cnt_r;
  logic          out_valid_r, load_out, start;

  assign sum       = root_r + bit_r;
  assign out_empty = !out_valid_r;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    start     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          start     = 1'b1;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (cnt_r == CW'(1)) state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_r || out_pop) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ed_r   <= q_data;
      rem_r  <= q_data.dsq;
      root_r <= '0;
      bit_r  <= DW'(1) << (DW - 2);
    end else if (state_r == BK_RUN) begin
      if (rem_r >= sum) begin
        rem_r  <= rem_r - sum;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (load_out) begin
      out_from_hit          <= ed_r.from_hit;
      out_to_hit            <= ed_r.to_hit;
      out_edge_length       <= (root_r > DW'({LEN_W{1'b1}})) ? {LEN_W{1'b1}}
                                                             : root_r[LEN_W-1:0];
      out_last_edge         <= ed_r.last;
      out_full_causal_edges <= ed_r.total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) cnt_r <= CW'(ITER);
      else if (state_r == BK_RUN) cnt_r <= cnt_r - 1'b1;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

endmodule

FILE: rtl/causal_knn_edge_builder.sv
// Scan: a hit numbered i scans min(i, WINDOW) stored hits at one per cycle, over one
//   memory read port; a new hit is taken only after every edge of the last one is queued.
// Edges: each edge waits for room in the edge queue; each edge's square root is computed
//   iteratively in the back unit, so short scans with many edges stall on it.
// Reset: synchronous, active low; clears counters, queue and handshake state. The window
//   memory is not cleared; only entries written in the current counter lap are read.
module causal_knn_edge_builder (
  input  logic                                clk,
  input  logic                                rst_n,
  // hit input queue
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [ckeb_pkg::COORD_W-1:0] in_hit_time,
  input  logic signed [ckeb_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [ckeb_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [ckeb_pkg::COORD_W-1:0] in_pos_z,
  // edge output queue
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [ckeb_pkg::IDX_W-1:0]          out_from_hit,
  output logic [ckeb_pkg::IDX_W-1:0]          out_to_hit,
  output logic [ckeb_pkg::LEN_W-1:0]          out_edge_length,
  output logic                                out_last_edge,
  output logic [ckeb_pkg::TOT_W-1:0]          out_full_causal_edges,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ckeb_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [ckeb_pkg::CFG_DW-1:0]         cfg_data
);
  import ckeb_pkg::*;

  logic [TW_W-1:0]   time_weight_r;
  logic [MARG_W-1:0] causal_margin_r;
  logic [NC_W-1:0]   neighbour_count_r;

  hit_t    in_hit;
  q_stat_t q_stat;
  edge_t   q_wdata, q_rdata;
  logic    q_push, q_pop;

  // registers always writable; software writes must wait for an idle block (unenforced)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_weight_r     <= TW_RESET;
      causal_margin_r   <= MARG_RESET;
      neighbour_count_r <= NC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIME_WEIGHT:   time_weight_r     <= cfg_data[TW_W-1:0];
        CFG_CAUSAL_MARGIN: causal_margin_r   <= cfg_data[MARG_W-1:0];
        CFG_NEIGH_COUNT:   neighbour_count_r <= cfg_data[NC_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign in_hit.t = in_hit_time;
  assign in_hit.x = in_pos_x;
  assign in_hit.y = in_pos_y;
  assign in_hit.z = in_pos_z;

  // front: window scan, causal test, ranking and edge list
  ckeb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_hit          (in_hit),
    .time_weight     (time_weight_r),
    .causal_margin   (causal_margin_r),
    .neighbour_count (neighbour_count_r),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_data          (q_wdata)
  );

  // short edge queue decoupling scan from square root
  ckeb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  // back: iterative square root and output register
  ckeb_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_stat                (q_stat),
    .q_data                (q_rdata),
    .q_pop                 (q_pop),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_from_hit          (out_from_hit),
    .out_to_hit            (out_to_hit),
    .out_edge_length       (out_edge_length),
    .out_last_edge         (out_last_edge),
    .out_full_causal_edges (out_full_causal_edges)
  );

  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("edge queue overflow");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("edge queue underflow");

  // a hit transfer makes the front busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("front took no hit");

endmodule

FILE: tb/causal_knn_edge_builder_tb.sv
module causal_knn_edge_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ckeb_pkg::*;

  // Cycles with no transfer on any port before the run is declared hung.
  // Slowest legal case: full window scan plus six square roots plus the
  // longest receiver stall plus the longest sender gap, taken many times over.
  localparam int HANG_LIMIT = 30000;
  localparam int SETTLE     = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_push;
  logic                      in_full;
  logic signed [COORD_W-1:0] in_hit_time, in_pos_x, in_pos_y, in_pos_z;
  logic                      out_empty;
  logic                      out_pop = 1'b0;
  logic [IDX_W-1:0]          out_from_hit, out_to_hit;
  logic [LEN_W-1:0]          out_edge_length;
  logic                      out_last_edge;
  logic [TOT_W-1:0]          out_full_causal_edges;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IW-1:0]         cfg_index;
  logic [CFG_DW-1:0]         cfg_data;

  causal_knn_edge_builder dut (.*);

  always #1 clk = ~clk;

  typedef struct {
    logic [IDX_W-1:0] from_hit;
    logic [IDX_W-1:0] to_hit;
    logic [LEN_W-1:0] edge_length;
    logic             last_edge;
    logic [TOT_W-1:0] full_causal_edges;
  } edge_rec_t;

  // Edges still owed by the block, oldest first.
  edge_rec_t edge_q[$];

  // Shadow of the block: stored hits, hit numbering, running total, registers.
  longint          win_t[WINDOW], win_x[WINDOW], win_y[WINDOW], win_z[WINDOW];
  logic [IDX_W-1:0] hit_num;
  logic [TOT_W-1:0] causal_total;
  logic [TW_W-1:0]   sh_weight;
  logic [MARG_W-1:0] sh_margin;
  logic [NC_W-1:0]   sh_k;

  int  errors = 0;
  int  hits_sent = 0;
  int  edges_seen = 0;
  int  cfg_writes = 0;
  bit  quiet = 0;          // no idling on either side while set
  int  pop_stall = 0;
  int  hang_cnt = 0;

  // hit generator track, so that most hits form causal chains
  logic [COORD_W-1:0] trk_t, trk_x, trk_y, trk_z;
  logic [COORD_W-1:0] prev_t, prev_x, prev_y, prev_z;

  function automatic longint unsigned sq_gap(longint a, longint b);
    longint unsigned d;
    d = (a > b) ? longint'(a - b) : longint'(b - a);
    return d * d;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Works out the edges for one accepted hit and queues them.
  task automatic predict_edges(input logic [COORD_W-1:0] ht, hx, hy, hz);
    longint          ct, cx, cy, cz;
    longint unsigned s, t, dd;
    longint unsigned best_d[MAX_K];
    logic [IDX_W-1:0] best_j[MAX_K];
    int              nb, k, look, caus, pos, m, rest;
    logic [IDX_W-1:0] i, j;
    bit              all_earlier;
    edge_rec_t       pend[$];
    edge_rec_t       e;

    ct = longint'($signed(ht)); cx = longint'($signed(hx));
    cy = longint'($signed(hy)); cz = longint'($signed(hz));
    i = hit_num;
    k = (sh_k == 0) ? 1 : (sh_k > MAX_K) ? MAX_K : int'(sh_k);
    nb = 0;
    caus = 0;
    look = (i < WINDOW) ? int'(i) : WINDOW;
    for (int d = 1; d <= look; d++) begin
      j = i - IDX_W'(d);
      s = sq_gap(win_x[j % WINDOW], cx) + sq_gap(win_y[j % WINDOW], cy)
        + sq_gap(win_z[j % WINDOW], cz);
      t = (sq_gap(win_t[j % WINDOW], ct) * longint'(sh_weight)) >> 16;
      if (s + longint'(sh_margin) < t) begin
        caus++;
        dd = s + t;
        pos = 0;
        while (pos < nb && (best_d[pos] < dd || (best_d[pos] == dd && best_j[pos] > j)))
          pos++;
        if (pos < k) begin
          m = (nb < k) ? nb : k - 1;
          while (m > pos) begin
            best_j[m] = best_j[m-1];
            best_d[m] = best_d[m-1];
            m--;
          end
          best_j[pos] = j;
          best_d[pos] = dd;
          if (nb < k) nb++;
        end
      end
    end

    // ranked causal edges first
    for (int c = 0; c < ((caus >= k) ? k : caus); c++) begin
      e.from_hit = best_j[c];
      e.edge_length = LEN_W'(int_sqrt(best_d[c]));
      pend = {pend, e};
    end
    if (caus >= k) begin
      causal_total = (causal_total > 32'hFFFF_FFFF - k) ? 32'hFFFF_FFFF : causal_total + k;
    end else begin
      rest = k - caus;
      all_earlier = (caus == 0) ? (rest >= i) : (rest > i);
      for (int n = 0; n < (all_earlier ? int'(i) : rest); n++) begin
        j = all_earlier ? IDX_W'(n) : i - IDX_W'(n + 1);
        dd = sq_gap(win_x[j % WINDOW], cx) + sq_gap(win_y[j % WINDOW], cy)
           + sq_gap(win_z[j % WINDOW], cz)
           + ((sq_gap(win_t[j % WINDOW], ct) * longint'(sh_weight)) >> 16);
        e.from_hit = j;
        e.edge_length = LEN_W'(int_sqrt(dd));
        pend = {pend, e};
      end
    end

    foreach (pend[n]) begin
      pend[n].to_hit = i;
      pend[n].full_causal_edges = causal_total;
      pend[n].last_edge = (n == pend.size() - 1);
      edge_q = {edge_q, pend[n]};
    end

    win_t[i % WINDOW] = ct; win_x[i % WINDOW] = cx;
    win_y[i % WINDOW] = cy; win_z[i % WINDOW] = cz;
    hit_num = i + 1'b1;
  endtask

  // Mostly short gaps, some medium, a few long.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  // One hit transfer; returns just after the edge that took it, or after the random sender gap.
  task automatic send_hit(input logic [COORD_W-1:0] ht, hx, hy, hz);
    int gap;
    in_hit_time <= ht;
    in_pos_x    <= hx;
    in_pos_y    <= hy;
    in_pos_z    <= hz;
    in_push     <= 1'b1;
    do @(posedge clk); while (in_full);
    predict_edges(ht, hx, hy, hz);
    hits_sent++;
    prev_t = ht; prev_x = hx; prev_y = hy; prev_z = hz;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender until every owed edge has come out, then lets the
  // block settle (a hit numbered zero gives no edge but may still be in flight).
  task automatic drain();
    in_push <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One register transfer, then the write channel idles before the task returns.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_TIME_WEIGHT:   sh_weight = val[TW_W-1:0];
      CFG_CAUSAL_MARGIN: sh_margin = val[MARG_W-1:0];
      CFG_NEIGH_COUNT:   sh_k      = val[NC_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [TW_W-1:0] w, input logic [MARG_W-1:0] mg,
                          input logic [NC_W-1:0] k);
    drain();
    write_reg(CFG_TIME_WEIGHT, CFG_DW'(w));
    write_reg(CFG_CAUSAL_MARGIN, mg);
    write_reg(CFG_NEIGH_COUNT, CFG_DW'(k));
  endtask

  function automatic logic [COORD_W-1:0] extreme_val();
    case ($urandom_range(0, 3))
      0: return 24'h7F_FFFF;
      1: return 24'h80_0000;
      2: return 24'h00_0000;
      default: return 24'hFF_FFFF;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] v, input int span);
    return v + COORD_W'($urandom_range(0, 2 * span)) - COORD_W'(span);
  endfunction

  // Random hit: mostly causal chains along a track, plus repeats (ties),
  // fully random noise and extreme values.
  task automatic random_hit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      trk_t = COORD_W'($urandom); trk_x = COORD_W'($urandom);
      trk_y = COORD_W'($urandom); trk_z = COORD_W'($urandom);
    end
    if (r < 58) begin
      trk_t = trk_t + COORD_W'($urandom_range(200, 6000));
      trk_x = nudge(trk_x, 300);
      trk_y = nudge(trk_y, 300);
      trk_z = nudge(trk_z, 300);
      send_hit(trk_t, trk_x, trk_y, trk_z);
    end else if (r < 72) begin
      send_hit(prev_t, prev_x, prev_y, prev_z);
    end else if (r < 92) begin
      send_hit(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
               COORD_W'($urandom));
    end else begin
      send_hit(extreme_val(), extreme_val(), extreme_val(), extreme_val());
    end
  endtask

  // --- tests -------------------------------------------------------------

  // First hit, extremes, exact repeats and a short causal chain at reset settings.
  task automatic test_directed();
    send_hit(24'h0, 24'h0, 24'h0, 24'h0);              // first hit: no edge
    send_hit(24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF);
    send_hit(24'h80_0000, 24'h80_0000, 24'h80_0000, 24'h80_0000);
    send_hit(24'h80_0000, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF);
    send_hit(24'h10, 24'h20, 24'h30, 24'h40);
    send_hit(24'h10, 24'h20, 24'h30, 24'h40);          // equal distance ties
    send_hit(24'h10, 24'h20, 24'h30, 24'h40);
    for (int n = 0; n < 8; n++)                        // causal chain, k fills up
      send_hit(COORD_W'(5000 * (n + 1)), COORD_W'(10 * n), 24'hFF_FFF0, COORD_W'(3 * n));
    send_hit(24'd60000, 24'd35, 24'hFF_FFF0, 24'd10);  // many causal, ranked
    send_hit(24'h7F_FFFF, 24'h0, 24'h0, 24'h0);
    send_hit(24'h80_0000, 24'h0, 24'h0, 24'h0);
    drain();                                           // sender holds until drained
  endtask

  // Register sweep: extremes and out-of-range neighbour counts, each with traffic.
  task automatic test_reg_sweep();
    logic [TW_W-1:0]   w_list[6]  = '{16'hFFFF, 16'h0, 16'd5898, 16'd5898, 16'd30000, 16'd1};
    logic [MARG_W-1:0] m_list[6]  = '{20'd0, 20'hFFFFF, 20'd1, 20'd1, 20'd50000, 20'd0};
    logic [NC_W-1:0]   k_list[6]  = '{3'd1, 3'd6, 3'd0, 3'd7, 3'd3, 3'd2};
    for (int p = 0; p < 6; p++) begin
      set_regs(w_list[p], m_list[p], k_list[p]);
      quiet = (p == 2);
      for (int n = 0; n < 40; n++) random_hit();
    end
    quiet = 0;
    drain();
    write_reg(CFG_UNUSED, CFG_DW'($urandom));          // ignored index
    for (int n = 0; n < 10; n++) random_hit();
  endtask

  task automatic test_random();
    for (int p = 0; p < 4; p++) begin
      set_regs(TW_W'($urandom),
               (p == 0) ? CFG_DW'($urandom) : CFG_DW'($urandom_range(0, 2000)),
               NC_W'($urandom_range(1, MAX_K)));
      for (int n = 0; n < 40; n++) random_hit();
    end
    set_regs(16'd5898, 20'd1, 3'd6);
  endtask

  // --- result side: stall control and field checks -----------------------
  always @(posedge clk) begin
    edge_rec_t e;
    if (rst_n && out_pop && !out_empty) begin
      edges_seen++;
      if (edge_q.size() == 0) begin
        $error("unexpected edge: from_hit %0d to_hit %0d", out_from_hit, out_to_hit);
        errors++;
      end else begin
        e = edge_q.pop_front();
        if (out_from_hit !== e.from_hit) begin
          $error("from_hit: expected %0d actual %0d", e.from_hit, out_from_hit);
          errors++;
        end
        if (out_to_hit !== e.to_hit) begin
          $error("to_hit: expected %0d actual %0d", e.to_hit, out_to_hit);
          errors++;
        end
        if (out_edge_length !== e.edge_length) begin
          $error("edge_length: expected %0d actual %0d", e.edge_length, out_edge_length);
          errors++;
        end
        if (out_last_edge !== e.last_edge) begin
          $error("last_edge: expected %0d actual %0d", e.last_edge, out_last_edge);
          errors++;
        end
        if (out_full_causal_edges !== e.full_causal_edges) begin
          $error("full_causal_edges: expected %0d actual %0d",
                 e.full_causal_edges, out_full_causal_edges);
          errors++;
        end
      end
    end
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_stall > 0) begin
      pop_stall--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) pop_stall = pick_gap();
    end
  end

  // watchdog: no transfer anywhere for too long
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      hang_cnt <= 0;
    else
      hang_cnt <= hang_cnt + 1;
    if (hang_cnt >= HANG_LIMIT) begin
      $display("causal_knn_edge_builder_tb NOT OK");
      $finish;
    end
  end

  initial begin
    in_push = 1'b0;
    in_hit_time = '0; in_pos_x = '0; in_pos_y = '0; in_pos_z = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    hit_num = '0; causal_total = '0;
    sh_weight = TW_RESET; sh_margin = MARG_RESET; sh_k = NC_RESET;
    trk_t = '0; trk_x = '0; trk_y = '0; trk_z = '0;
    prev_t = '0; prev_x = '0; prev_y = '0; prev_z = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_reg_sweep();
    test_random();

    drain();
    repeat (200) @(posedge clk);
    if (edge_q.size() != 0) begin
      $error("%0d expected edges never came out", edge_q.size());
      errors++;
    end
    $display("ran %0d hits through %0d register writes, %0d edges checked",
             hits_sent, cfg_writes, edges_seen);
    $display("covered ties, extremes, zero and oversized neighbour counts, random stalls");
    if (errors == 0) begin
      $display("causal_knn_edge_builder_tb OK");
    end else begin
      $display("causal_knn_edge_builder_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ckeb_pkg.sv
rtl/ckeb_front.sv
rtl/ckeb_fifo.sv
rtl/ckeb_back.sv
rtl/causal_knn_edge_builder.sv
tb/causal_knn_edge_builder_tb.sv
